FILE: src/cdac_pkg.sv
`timescale 1ns / 1ps

package cdac_pkg;

   localparam int SampleBits   = 16;
   localparam int DiffBits     = SampleBits + 1;
   localparam int StepShift    = 6;
   localparam int HalfStep     = 32;
   localparam int QuotBits     = DiffBits - StepShift + 1;
   localparam int CodeBits     = 8;
   localparam int WidthBits    = 4;
   localparam int ResidBits    = 2;

   localparam logic [WidthBits-1:0] CodeWidthReset = 4'd4;
   localparam logic [WidthBits-1:0] CodeWidthMin   = 4'd1;
   localparam logic [WidthBits-1:0] CodeWidthMax   = 4'd8;

   localparam logic [ResidBits-1:0] ResidNewAnchor = 2'd3;

   // One coded result as it leaves the block.
   typedef struct packed {
      logic                         anchor_valid;
      logic signed [SampleBits-1:0] anchor_sample;
      logic                         delta_valid;
      logic [CodeBits-1:0]          delta_code;
      logic                         residual_valid;
      logic [ResidBits-1:0]         residual_code;
   } cdac_result_type;

endpackage

FILE: src/cdac_quant.sv
`timescale 1ns / 1ps

// Quantizes one sample against the previous one and builds the coded result.
module cdac_quant (
   input  logic signed [cdac_pkg::SampleBits-1:0] sample,
   input  logic signed [cdac_pkg::SampleBits-1:0] prev_sample,
   input  logic                                   block_start,
   input  logic [cdac_pkg::WidthBits-1:0]         code_bits,
   output cdac_pkg::cdac_result_type              result
);
   import cdac_pkg::*;

   logic [WidthBits-1:0]         width;
   logic [CodeBits:0]            offset;
   logic signed [QuotBits-1:0]   off_s;
   logic signed [DiffBits-1:0]   diff;
   logic                         neg;
   logic [DiffBits-1:0]          mag;
   logic [DiffBits-1:0]          mag_rnd;
   logic [QuotBits-2:0]          qmag;
   logic signed [QuotBits-1:0]   quot;
   logic signed [StepShift:0]    rmag;
   logic signed [StepShift:0]    rem;
   logic                         fits;
   logic                         small_rem;

   always_comb begin
      if (code_bits < CodeWidthMin) begin
         width = CodeWidthMin;
      end else if (code_bits > CodeWidthMax) begin
         width = CodeWidthMax;
      end else begin
         width = code_bits;
      end
      offset = (CodeBits+1)'(1) << (width - CodeWidthMin);
      off_s  = $signed(QuotBits'(offset));

      diff    = $signed({sample[SampleBits-1], sample})
              - $signed({prev_sample[SampleBits-1], prev_sample});
      neg     = diff[DiffBits-1];
      mag     = neg ? DiffBits'(-diff) : DiffBits'(diff);
      mag_rnd = mag + DiffBits'(HalfStep);
      qmag    = mag_rnd[DiffBits-1:StepShift];
      quot    = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

      // Remainder of the magnitude after rounding lies in -32..31.
      rmag = $signed({mag[StepShift-1], mag[StepShift-1:0]});
      rem  = neg ? -rmag : rmag;

      small_rem = (rem == 7'sd0) || (rem == 7'sd1) || (rem == -7'sd1);
      fits      = (quot >= -off_s) && (quot < off_s);

      result = '0;
      if (block_start) begin
         result.anchor_valid  = 1'b1;
         result.anchor_sample = sample;
      end else begin
         result.residual_valid = 1'b1;
         if (fits && small_rem) begin
            result.delta_valid   = 1'b1;
            result.delta_code    = quot[CodeBits-1:0] + offset[CodeBits-1:0];
            result.residual_code = rem[ResidBits-1:0] + ResidBits'(1);
         end else begin
            result.anchor_valid  = 1'b1;
            result.anchor_sample = sample;
            result.residual_code = ResidNewAnchor;
         end
      end
   end

endmodule

FILE: src/coarse_delta_anchor_coder_core.sv
`timescale 1ns / 1ps

// Coarse delta / anchor coder. Each accepted sample beat yields exactly one
// result beat. A block-start sample is sent as an anchor. Any other sample is
// coded as its difference from the previous raw sample, rounded to a multiple
// of 64 (halves away from zero): when the quotient fits the signed code width
// set by csr_data (1..8, 0 reads as 1, above 8 reads as 8) and the remainder
// is -1, 0 or +1, the beat carries delta_code = quotient + 2^(width-1) and
// residual_code = remainder + 1; otherwise it carries residual_code 3 and the
// sample as a new anchor. The block takes one sample per cycle while rsp_ready
// is high. An accepted sample waits in the input register and then goes
// through the subtract, round and compare path into the output register. The
// previous sample is updated on every accepted beat. The code width register
// should only be written while no beat is in flight.
module coarse_delta_anchor_coder_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [cdac_pkg::SampleBits-1:0] req_sample,
   input  logic                                   req_block_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_anchor_valid,
   output logic signed [cdac_pkg::SampleBits-1:0] rsp_anchor_sample,
   output logic                                   rsp_delta_valid,
   output logic [cdac_pkg::CodeBits-1:0]          rsp_delta_code,
   output logic                                   rsp_residual_valid,
   output logic [cdac_pkg::ResidBits-1:0]         rsp_residual_code,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cdac_pkg::WidthBits-1:0]         csr_data
);
   import cdac_pkg::*;

   logic [WidthBits-1:0]         code_bits_ff;
   logic signed [SampleBits-1:0] prev_ff;

   // Input register.
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic signed [SampleBits-1:0] s1_sample_ff;
   logic signed [SampleBits-1:0] s1_prev_ff;
   logic                         s1_start_ff;

   // Output register.
   logic                         out_valid_ff;
   logic                         out_valid_in;
   cdac_result_type              out_ff;
   cdac_result_type              result;

   logic req_fire;
   logic out_load;
   logic s1_move;

   // The output register loads when empty or when its beat leaves now; the
   // input register drains into it and refills in the same cycle.
   assign out_load  = !out_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_load;
   assign req_ready = !s1_valid_ff || out_load;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   cdac_quant u_quant (
      .sample      (s1_sample_ff),
      .prev_sample (s1_prev_ff),
      .block_start (s1_start_ff),
      .code_bits   (code_bits_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         code_bits_ff <= CodeWidthReset;
         prev_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            code_bits_ff <= csr_data;
         end
         if (req_fire) begin
            prev_ff <= req_sample;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff <= req_sample;
         s1_prev_ff   <= prev_ff;
         s1_start_ff  <= req_block_start;
      end
      if (s1_move) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_anchor_valid   = out_ff.anchor_valid;
   assign rsp_anchor_sample  = out_ff.anchor_sample;
   assign rsp_delta_valid    = out_ff.delta_valid;
   assign rsp_delta_code     = out_ff.delta_code;
   assign rsp_residual_valid = out_ff.residual_valid;
   assign rsp_residual_code  = out_ff.residual_code;

endmodule

FILE: src/cdac_checker.sv
`timescale 1ns / 1ps

module cdac_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic                                   rsp_anchor_valid,
   input logic signed [cdac_pkg::SampleBits-1:0] rsp_anchor_sample,
   input logic                                   rsp_delta_valid,
   input logic [cdac_pkg::CodeBits-1:0]          rsp_delta_code,
   input logic                                   rsp_residual_valid,
   input logic [cdac_pkg::ResidBits-1:0]         rsp_residual_code
);
   import cdac_pkg::*;

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_anchor_sample)
         && $stable(rsp_delta_code) && $stable(rsp_residual_code))
      else $error("result payload changed while stalled");

   // A coded sample carries either a delta or a new anchor, never both.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_residual_valid |-> rsp_anchor_valid != rsp_delta_valid)
      else $error("coded beat must carry exactly one of delta and anchor");

   // A block start is always an anchor with no delta.
   a_start_anchor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_residual_valid |->
         rsp_anchor_valid && !rsp_delta_valid && rsp_residual_code == '0)
      else $error("block start beat malformed");

   // Residual code agrees with the kind of beat.
   a_resid_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_residual_valid |->
         (rsp_delta_valid && rsp_residual_code != ResidNewAnchor)
         || (rsp_anchor_valid && rsp_residual_code == ResidNewAnchor))
      else $error("residual code does not match beat kind");

   // Unused fields read as zero.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_anchor_valid || rsp_anchor_sample == '0)
         && (rsp_delta_valid || rsp_delta_code == '0))
      else $error("unused result field not zero");

endmodule

bind coarse_delta_anchor_coder_core cdac_checker u_cdac_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_anchor_valid   (rsp_anchor_valid),
   .rsp_anchor_sample  (rsp_anchor_sample),
   .rsp_delta_valid    (rsp_delta_valid),
   .rsp_delta_code     (rsp_delta_code),
   .rsp_residual_valid (rsp_residual_valid),
   .rsp_residual_code  (rsp_residual_code)
);
